### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked concurrent assertions on clock, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset.
`define KVHP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define KVHP_ASSERT_NEXT(label, ante, cons, msg) \
   `KVHP_ASSERT(label, (ante) |=> (cons), msg)

`endif

### sv/kvhp_pkg.sv
// ---------------------------------------------------------------------------
// kvhp_pkg
// Shared constants, payload types and the column weighting function of the
// 5x5 high-pass filter.
// ---------------------------------------------------------------------------
package kvhp_pkg;

   // Image geometry.
   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 4096;
   localparam int KERNEL_SIZE  = 5;
   localparam int LINES        = KERNEL_SIZE - 1;
   localparam int MIN_DIM      = 5;
   localparam int PIX_W        = 8;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(MAX_HEIGHT);
   localparam int LINE_WORD_W  = LINES * PIX_W;

   // Configuration registers.
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;
   localparam int WIDTH_RESET  = 1024;
   localparam int HEIGHT_RESET = 1024;

   // Comparison widths for the counters against the effective dimensions.
   localparam int WCMP_W = (WIDTH_REG_W > COL_W + 1) ? WIDTH_REG_W : COL_W + 1;
   localparam int HCMP_W = (HEIGHT_REG_W > ROW_W + 1) ? HEIGHT_REG_W : ROW_W + 1;

   // Arithmetic widths of the weighted column sums and the window sum.
   localparam int A_W   = 11;
   localparam int B_W   = 13;
   localparam int C_W   = 13;
   localparam int SUM_W = 15;

   // Result queue.
   localparam int RESULT_DEPTH = 8;
   localparam int FIFO_PTR_W   = $clog2(RESULT_DEPTH);
   localparam int FIFO_CNT_W   = FIFO_PTR_W + 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } req_data_type;

   typedef struct packed {
      logic [PIX_W-1:0] filtered;
      logic             row_end;
      logic             frame_end;
   } rsp_data_type;

   // One column of the window, already weighted by the three column profiles.
   typedef struct packed {
      logic signed [A_W-1:0] a;
      logic signed [B_W-1:0] b;
      logic signed [C_W-1:0] c;
   } col_sums_type;

   // Write port of the line store.
   typedef struct packed {
      logic                   en;
      logic [COL_W-1:0]       addr;
      logic [LINE_WORD_W-1:0] data;
   } ls_write_type;

   // Per-item marks carried down the pipeline.
   typedef struct packed {
      logic emit;
      logic row_end;
      logic frame_end;
   } tag_type;

   // Weights one column (top pixel first) by the outer, inner and centre
   // column profiles of the kernel: a = [-1 2 -2 2 -1], b = [2 -6 8 -6 2],
   // c = [-2 8 -12 8 -2].
   function automatic col_sums_type col_weigh(input logic [PIX_W-1:0] p0,
                                              input logic [PIX_W-1:0] p1,
                                              input logic [PIX_W-1:0] p2,
                                              input logic [PIX_W-1:0] p3,
                                              input logic [PIX_W-1:0] p4);
      logic signed [SUM_W-1:0] e0;
      logic signed [SUM_W-1:0] e1;
      logic signed [SUM_W-1:0] e2;
      logic signed [SUM_W-1:0] e3;
      logic signed [SUM_W-1:0] e4;
      logic signed [SUM_W-1:0] sa;
      logic signed [SUM_W-1:0] sb;
      logic signed [SUM_W-1:0] sc;
      col_sums_type            r;
      e0 = $signed({{(SUM_W-PIX_W){1'b0}}, p0});
      e1 = $signed({{(SUM_W-PIX_W){1'b0}}, p1});
      e2 = $signed({{(SUM_W-PIX_W){1'b0}}, p2});
      e3 = $signed({{(SUM_W-PIX_W){1'b0}}, p3});
      e4 = $signed({{(SUM_W-PIX_W){1'b0}}, p4});
      sa = -e0 + (e1 <<< 1) - (e2 <<< 1) + (e3 <<< 1) - e4;
      sb = (e0 <<< 1) - ((e1 <<< 2) + (e1 <<< 1)) + (e2 <<< 3)
           - ((e3 <<< 2) + (e3 <<< 1)) + (e4 <<< 1);
      sc = -(e0 <<< 1) + (e1 <<< 3) - ((e2 <<< 3) + (e2 <<< 2))
           + (e3 <<< 3) - (e4 <<< 1);
      r.a = sa[A_W-1:0];
      r.b = sb[B_W-1:0];
      r.c = sc[C_W-1:0];
      return r;
   endfunction

endpackage

### sv/kvhp_line_store.sv
// ---------------------------------------------------------------------------
// kvhp_line_store
// Four line stores packed into one word per column, with a registered read
// and a bypass for a read of the column written in the same cycle.
// ---------------------------------------------------------------------------
module kvhp_line_store (
   input  logic                             clock,
   input  logic                             rd_en,
   input  logic [kvhp_pkg::COL_W-1:0]       rd_addr,
   input  kvhp_pkg::ls_write_type           wr,
   output logic [kvhp_pkg::LINE_WORD_W-1:0] rd_data
);

   logic [kvhp_pkg::LINE_WORD_W-1:0] mem [kvhp_pkg::MAX_WIDTH];
   logic [kvhp_pkg::LINE_WORD_W-1:0] rd_ff;
   logic [kvhp_pkg::LINE_WORD_W-1:0] byp_data_ff;
   logic                             byp_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read port; a read that meets a write to the same column takes the new word.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff       <= mem[rd_addr];
         byp_ff      <= wr.en && (wr.addr == rd_addr);
         byp_data_ff <= wr.data;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_ff;

endmodule

### sv/kvhp_column_cell.sv
// ---------------------------------------------------------------------------
// kvhp_column_cell
// One column of the 5x5 window, held as its weighted sums and handed to the
// left neighbour on every shift.
// ---------------------------------------------------------------------------
module kvhp_column_cell (
   input  logic                   clock,
   input  logic                   shift_en,
   input  kvhp_pkg::col_sums_type sums_in,
   output kvhp_pkg::col_sums_type sums_out
);

   kvhp_pkg::col_sums_type sums_ff;
   kvhp_pkg::col_sums_type sums_in_sel;

   // Take the neighbour's column on a shift, otherwise hold.
   always_comb begin
      sums_in_sel = shift_en ? sums_in : sums_ff;
   end

   always_ff @(posedge clock) begin
      sums_ff <= sums_in_sel;
   end

   assign sums_out = sums_ff;

endmodule

### sv/kvhp_result_fifo.sv
// ---------------------------------------------------------------------------
// kvhp_result_fifo
// Small result queue that decouples the filter pipeline from the output
// channel.
// ---------------------------------------------------------------------------
module kvhp_result_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  kvhp_pkg::rsp_data_type push_data,
   input  logic                   pop,
   output logic                   out_valid,
   output kvhp_pkg::rsp_data_type out_data
);

   kvhp_pkg::rsp_data_type             entries_ff [kvhp_pkg::RESULT_DEPTH];
   logic [kvhp_pkg::FIFO_PTR_W-1:0]    wr_ptr_ff;
   logic [kvhp_pkg::FIFO_PTR_W-1:0]    rd_ptr_ff;
   logic [kvhp_pkg::FIFO_CNT_W-1:0]    count_ff;
   logic [kvhp_pkg::FIFO_CNT_W-1:0]    count_in;

   // Occupancy after this cycle's push and pop.
   always_comb begin
      count_in = count_ff + kvhp_pkg::FIFO_CNT_W'(push) - kvhp_pkg::FIFO_CNT_W'(pop);
   end

   // Pointers and count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = entries_ff[rd_ptr_ff];

endmodule

### sv/kv_highpass_5x5_filter_top.sv
// ---------------------------------------------------------------------------
// kv_highpass_5x5_filter_top
// Streaming 5x5 KV high-pass filter over 8-bit grey images in raster order,
// valid-only borders, result = clamp(floor(S / 12), 0, 255).
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   pixel, frame_start
//   rsp_      out        rsp_valid/rsp_stall   filtered, row_end, frame_end
//   csr_      in         csr_valid/csr_ready   csr_index, csr_data
//
// One item is accepted per clock while req_stall is low. Its result is offered on
// rsp_ after the line store read, column weighting, window sum, then divide and
// clamp on the way into an eight-entry result queue.
// req_stall rises only when eight items are in flight or queued, so the
// input keeps flowing while a finished result is held by rsp_stall.
// Reset is synchronous and clears the control state only; the line stores
// need no clearing pass and the block takes items from the first cycle.
// ---------------------------------------------------------------------------
module kv_highpass_5x5_filter_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  kvhp_pkg::req_data_type            req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output kvhp_pkg::rsp_data_type            rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  kvhp_pkg::csr_index_type           csr_index,
   input  logic [kvhp_pkg::CSR_DATA_W-1:0]   csr_data
);

`include "assert_macros.svh"

   localparam int WC = kvhp_pkg::WCMP_W;
   localparam int HC = kvhp_pkg::HCMP_W;
   localparam int SW = kvhp_pkg::SUM_W;
   localparam logic [kvhp_pkg::FIFO_CNT_W-1:0] FULL_COUNT =
      kvhp_pkg::FIFO_CNT_W'(kvhp_pkg::RESULT_DEPTH);

   // Divide by twelve: below LOW_LIMIT the result is zero, from HIGH_LIMIT
   // on it saturates, and between them floor(S/4) is divided by three.
   localparam logic signed [SW-1:0] LOW_LIMIT  = SW'(12);
   localparam logic signed [SW-1:0] HIGH_LIMIT = SW'(3072);
   localparam int QX_W        = 10;
   localparam int RECIP_W     = 10;
   localparam int RECIP_SHIFT = 11;
   localparam logic [RECIP_W-1:0] RECIP_THIRD = RECIP_W'(683);

   // Configuration registers.
   logic [kvhp_pkg::WIDTH_REG_W-1:0]  image_width_ff;
   logic [kvhp_pkg::HEIGHT_REG_W-1:0] image_height_ff;

   // Raster counters.
   logic [kvhp_pkg::COL_W-1:0] col_ff;
   logic [kvhp_pkg::ROW_W-1:0] row_ff;

   // Item accounting for the result queue.
   logic [kvhp_pkg::FIFO_CNT_W-1:0] inflight_ff;
   logic [kvhp_pkg::FIFO_CNT_W-1:0] inflight_in;

   // Pipeline stages.
   logic                             s1_valid_ff;
   logic [kvhp_pkg::COL_W-1:0]       s1_addr_ff;
   logic [kvhp_pkg::PIX_W-1:0]       s1_px_ff;
   kvhp_pkg::tag_type                s1_tag_ff;
   logic                             s2_valid_ff;
   kvhp_pkg::tag_type                s2_tag_ff;
   logic                             s3_valid_ff;
   kvhp_pkg::tag_type                s3_tag_ff;
   logic signed [SW-1:0]             s3_sum_ff;

   logic                             accept;
   logic                             pop;
   logic                             drop;
   logic [WC-1:0]                    width_ext;
   logic [WC-1:0]                    w_eff;
   logic [HC-1:0]                    height_ext;
   logic [HC-1:0]                    h_eff;
   logic [kvhp_pkg::COL_W-1:0]       col_cur;
   logic [kvhp_pkg::ROW_W-1:0]       row_cur;
   logic [WC-1:0]                    col_inc;
   logic [HC-1:0]                    row_inc;
   kvhp_pkg::tag_type                tag_in;
   logic [kvhp_pkg::COL_W-1:0]       col_in;
   logic [kvhp_pkg::ROW_W-1:0]       row_in;

   logic [kvhp_pkg::LINE_WORD_W-1:0] ls_word;
   kvhp_pkg::ls_write_type           ls_wr;
   kvhp_pkg::col_sums_type           new_sums;
   kvhp_pkg::col_sums_type           cell_q [kvhp_pkg::KERNEL_SIZE];
   logic signed [SW-1:0]             window_sum;

   logic [QX_W-1:0]                  quot_x;
   logic [QX_W+RECIP_W-1:0]          quot_prod;
   logic [kvhp_pkg::PIX_W-1:0]       filtered;
   kvhp_pkg::rsp_data_type           push_data;
   logic                             push;

   // Handshakes.
   assign csr_ready = 1'b1;
   assign req_stall = (inflight_ff == FULL_COUNT);
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign drop      = s3_valid_ff && !s3_tag_ff.emit;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= kvhp_pkg::WIDTH_REG_W'(kvhp_pkg::WIDTH_RESET);
         image_height_ff <= kvhp_pkg::HEIGHT_REG_W'(kvhp_pkg::HEIGHT_RESET);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            kvhp_pkg::REG_IMAGE_WIDTH: begin
               image_width_ff <= csr_data[kvhp_pkg::WIDTH_REG_W-1:0];
            end
            kvhp_pkg::REG_IMAGE_HEIGHT: begin
               image_height_ff <= csr_data[kvhp_pkg::HEIGHT_REG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Effective dimensions, saturated to the supported range.
   always_comb begin
      width_ext  = WC'(image_width_ff);
      height_ext = HC'(image_height_ff);
      if (width_ext < WC'(kvhp_pkg::MIN_DIM)) begin
         w_eff = WC'(kvhp_pkg::MIN_DIM);
      end else if (width_ext > WC'(kvhp_pkg::MAX_WIDTH)) begin
         w_eff = WC'(kvhp_pkg::MAX_WIDTH);
      end else begin
         w_eff = width_ext;
      end
      if (height_ext < HC'(kvhp_pkg::MIN_DIM)) begin
         h_eff = HC'(kvhp_pkg::MIN_DIM);
      end else if (height_ext > HC'(kvhp_pkg::MAX_HEIGHT)) begin
         h_eff = HC'(kvhp_pkg::MAX_HEIGHT);
      end else begin
         h_eff = height_ext;
      end
   end

   // Position of the incoming item, its marks and the next counter values.
   always_comb begin
      col_cur = req_data.frame_start ? '0 : col_ff;
      row_cur = req_data.frame_start ? '0 : row_ff;
      col_inc = WC'(col_cur) + WC'(1);
      row_inc = HC'(row_cur) + HC'(1);
      tag_in.emit      = (col_cur >= kvhp_pkg::COL_W'(kvhp_pkg::LINES))
                         && (row_cur >= kvhp_pkg::ROW_W'(kvhp_pkg::LINES));
      tag_in.row_end   = (WC'(col_cur) == w_eff - WC'(1));
      tag_in.frame_end = tag_in.row_end && (HC'(row_cur) == h_eff - HC'(1));
      if (col_inc >= w_eff) begin
         col_in = '0;
         row_in = (row_inc >= h_eff) ? '0 : row_inc[kvhp_pkg::ROW_W-1:0];
      end else begin
         col_in = col_inc[kvhp_pkg::COL_W-1:0];
         row_in = row_cur;
      end
   end

   // Counters, stage valids and item accounting.
   always_comb begin
      inflight_in = inflight_ff + kvhp_pkg::FIFO_CNT_W'(accept)
                    - kvhp_pkg::FIFO_CNT_W'(drop) - kvhp_pkg::FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         inflight_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         inflight_ff <= inflight_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff <= col_cur;
         s1_px_ff   <= req_data.pixel;
         s1_tag_ff  <= tag_in;
      end
      s2_tag_ff <= s1_tag_ff;
      s3_tag_ff <= s2_tag_ff;
      s3_sum_ff <= window_sum;
   end

   // Line stores: read at accept, rotate the column up one line in the cycle after.
   kvhp_line_store u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .wr      (ls_wr),
      .rd_data (ls_word)
   );

   always_comb begin
      ls_wr.en   = s1_valid_ff;
      ls_wr.addr = s1_addr_ff;
      ls_wr.data = {s1_px_ff, ls_word[kvhp_pkg::LINE_WORD_W-1:kvhp_pkg::PIX_W]};
      new_sums   = kvhp_pkg::col_weigh(ls_word[kvhp_pkg::PIX_W-1:0],
                                       ls_word[2*kvhp_pkg::PIX_W-1:kvhp_pkg::PIX_W],
                                       ls_word[3*kvhp_pkg::PIX_W-1:2*kvhp_pkg::PIX_W],
                                       ls_word[4*kvhp_pkg::PIX_W-1:3*kvhp_pkg::PIX_W],
                                       s1_px_ff);
   end

   // Window: a row of column cells, the newest on the right.
   for (genvar k = 0; k < kvhp_pkg::KERNEL_SIZE; k++) begin : g_cell
      if (k == kvhp_pkg::KERNEL_SIZE - 1) begin : g_last
         kvhp_column_cell u_cell (
            .clock    (clock),
            .shift_en (s1_valid_ff),
            .sums_in  (new_sums),
            .sums_out (cell_q[k])
         );
      end else begin : g_inner
         kvhp_column_cell u_cell (
            .clock    (clock),
            .shift_en (s1_valid_ff),
            .sums_in  (cell_q[k+1]),
            .sums_out (cell_q[k])
         );
      end
   end

   // Window sum: outer profile on the edge columns, inner next, centre in the middle.
   always_comb begin
      window_sum = SW'(cell_q[0].a) + SW'(cell_q[1].b) + SW'(cell_q[2].c)
                   + SW'(cell_q[3].b) + SW'(cell_q[4].a);
   end

   // Divide by twelve and clamp.
   always_comb begin
      quot_x    = s3_sum_ff[QX_W+1:2];
      quot_prod = (QX_W+RECIP_W)'(quot_x) * (QX_W+RECIP_W)'(RECIP_THIRD);
      if (s3_sum_ff < LOW_LIMIT) begin
         filtered = '0;
      end else if (s3_sum_ff >= HIGH_LIMIT) begin
         filtered = '1;
      end else begin
         filtered = quot_prod[RECIP_SHIFT+kvhp_pkg::PIX_W-1:RECIP_SHIFT];
      end
      push               = s3_valid_ff && s3_tag_ff.emit;
      push_data.filtered  = filtered;
      push_data.row_end   = s3_tag_ff.row_end;
      push_data.frame_end = s3_tag_ff.frame_end;
   end

   // Result queue towards the output channel.
   kvhp_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   // Checks.
   `KVHP_ASSERT(a_inflight_bound, inflight_ff <= FULL_COUNT, "items in flight exceed depth")
   `KVHP_ASSERT(a_result_counted, rsp_valid |-> (inflight_ff != '0), "result not counted")
   `KVHP_ASSERT_NEXT(a_first_pixel_silent, accept && req_data.frame_start,
                     s1_valid_ff && !s1_tag_ff.emit, "first pixel of a frame marked to emit")
   `KVHP_ASSERT(a_frame_end_row_end, (rsp_valid && rsp_data.frame_end) |-> rsp_data.row_end,
                "frame end without row end")

endmodule
